// ===== hdl/cen_pkg.sv =====
`default_nettype none

package cen_pkg;

    localparam int VALUE_W = 6;
    localparam int COUNT_W = 5;

    typedef enum logic [0:0] {
        REG_CHOOSE_COUNT  = 1'b0,
        REG_UNIVERSE_SIZE = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/cen_store.sv =====
`default_nettype none

module cen_store #(
    parameter int DEPTH = 16
) (
    input  wire logic                                           clk,
    input  wire logic                                           wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
    input  wire logic [cen_pkg::VALUE_W-1:0]                    wr_data,
    input  wire logic                                           rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
    output logic      [cen_pkg::VALUE_W-1:0]                    rd_data
);

    logic [cen_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [cen_pkg::VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/cen_unit.sv =====
`default_nettype none

module cen_unit #(
    parameter int IDX_W = 4
) (
    input  wire logic [cen_pkg::VALUE_W-1:0] a,
    input  wire logic [IDX_W-1:0]            idx,
    input  wire logic [cen_pkg::COUNT_W-1:0] k,
    input  wire logic [cen_pkg::VALUE_W-1:0] m,
    output logic                             lt,
    output logic                             eq,
    output logic [cen_pkg::VALUE_W-1:0]      inc
);

    logic [7:0] bound;
    logic [7:0] a_ext;

    // largest value allowed at position idx: m - k + 1 + idx
    assign bound = 8'(m) + 8'd1 + 8'(idx) - 8'(k);
    assign a_ext = 8'(a);
    assign lt    = (a_ext < bound);
    assign eq    = (a_ext == bound);
    assign inc   = a + cen_pkg::VALUE_W'(1);

endmodule

`default_nettype wire

// ===== hdl/combination_enumerator.sv =====
`default_nettype none

// Steps through the k-element subsets of 1..m in lexicographic order, one
// combination per request transaction, sent out smallest element first as k
// result transactions. The current combination lives in a small memory with
// one write and one read port, and one shared compare/increment unit walks it
// one position per cycle: a restart writes 1..k; an advance scans back from the
// last position and rewrites the tail; each element is then read out of the
// memory and presented. An exhausted or invalid-configuration answer is given
// at once, or after the backward scan when it is what finds the list used up.
// No new request is taken until the last result of the current one is taken.
module combination_enumerator #(
    parameter int MAX_CHOOSE   = 16,
    parameter int MAX_UNIVERSE = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [0:0]                      wr_index,
    input  wire logic [cen_pkg::VALUE_W-1:0]     wr_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            restart,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [cen_pkg::VALUE_W-1:0]          element_value,
    output logic                                 last_element,
    output logic                                 final_combination,
    output logic                                 exhausted
);

    localparam int IDX_W = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;

    cen_pkg::state_t state_reg, state_next;

    logic [cen_pkg::COUNT_W-1:0] choose_count_reg;
    logic [cen_pkg::VALUE_W-1:0] universe_size_reg;
    logic                        started_reg, started_next;
    logic                        done_reg, done_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [cen_pkg::VALUE_W-1:0] val_reg, val_next;

    logic                        out_valid_reg, out_valid_next;
    logic [cen_pkg::VALUE_W-1:0] out_value_reg, out_value_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_final_reg, out_final_next;
    logic                        out_exh_reg, out_exh_next;

    logic                        mem_wr_en;
    logic [IDX_W-1:0]            mem_wr_addr;
    logic [cen_pkg::VALUE_W-1:0] mem_wr_data;
    logic                        mem_rd_en;
    logic [IDX_W-1:0]            mem_rd_addr;
    logic [cen_pkg::VALUE_W-1:0] mem_rd_data;

    logic [cen_pkg::VALUE_W-1:0] unit_a;
    logic                        unit_lt;
    logic                        unit_eq;
    logic [cen_pkg::VALUE_W-1:0] unit_inc;

    logic                        cfg_bad;
    logic                        last_idx;
    logic                        in_xact;
    logic                        out_xact;

    cen_store #(
        .DEPTH (MAX_CHOOSE)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    cen_unit #(
        .IDX_W (IDX_W)
    ) u_unit (
        .a   (unit_a),
        .idx (idx_reg),
        .k   (choose_count_reg),
        .m   (universe_size_reg),
        .lt  (unit_lt),
        .eq  (unit_eq),
        .inc (unit_inc)
    );

    assign cfg_bad  = (choose_count_reg == '0)
                   || (7'(choose_count_reg) > 7'(universe_size_reg))
                   || (7'(choose_count_reg) > 7'(MAX_CHOOSE))
                   || (7'(universe_size_reg) > 7'(MAX_UNIVERSE));
    assign last_idx = (7'(idx_reg) == (7'(choose_count_reg) - 7'd1));
    assign in_ready = (state_reg == cen_pkg::ST_IDLE);
    assign in_xact  = in_valid && in_ready;
    assign out_xact = out_valid_reg && out_ready;
    assign unit_a   = (state_reg == cen_pkg::ST_FILL) ? val_reg : mem_rd_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            choose_count_reg  <= cen_pkg::COUNT_W'(1);
            universe_size_reg <= cen_pkg::VALUE_W'(1);
        end
        else if (wr_en)
        begin
            unique case (cen_pkg::reg_index_t'(wr_index))
                cen_pkg::REG_CHOOSE_COUNT:
                begin
                    choose_count_reg <= wr_data[cen_pkg::COUNT_W-1:0];
                end
                cen_pkg::REG_UNIVERSE_SIZE:
                begin
                    universe_size_reg <= wr_data;
                end
                default:
                begin
                    choose_count_reg <= choose_count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cen_pkg::ST_IDLE;
            started_reg   <= 1'b0;
            done_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            done_reg      <= done_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_final_reg <= out_final_next;
        out_exh_reg   <= out_exh_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        started_next   = started_reg;
        done_next      = done_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_final_next = out_final_reg;
        out_exh_next   = out_exh_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = idx_reg;
        mem_wr_data    = val_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = idx_reg;

        unique case (state_reg)
            cen_pkg::ST_IDLE:
            begin
                if (in_xact)
                begin
                    priority if (cfg_bad || (!restart && started_reg && done_reg))
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = '0;
                        out_last_next  = 1'b0;
                        out_final_next = 1'b0;
                        out_exh_next   = 1'b1;
                        state_next     = cen_pkg::ST_EMIT_WAIT;
                    end
                    else if (restart || !started_reg)
                    begin
                        started_next = 1'b1;
                        done_next    = 1'b0;
                        idx_next     = '0;
                        val_next     = cen_pkg::VALUE_W'(1);
                        state_next   = cen_pkg::ST_FILL;
                    end
                    else
                    begin
                        idx_next    = IDX_W'(choose_count_reg - cen_pkg::COUNT_W'(1));
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = IDX_W'(choose_count_reg - cen_pkg::COUNT_W'(1));
                        state_next  = cen_pkg::ST_SCAN;
                    end
                end
            end
            // find the rightmost position that can still grow
            cen_pkg::ST_SCAN:
            begin
                priority if (unit_lt)
                begin
                    val_next   = unit_inc;
                    state_next = cen_pkg::ST_FILL;
                end
                else if (idx_reg == '0)
                begin
                    done_next      = 1'b1;
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    out_last_next  = 1'b0;
                    out_final_next = 1'b0;
                    out_exh_next   = 1'b1;
                    state_next     = cen_pkg::ST_EMIT_WAIT;
                end
                else
                begin
                    idx_next    = idx_reg - IDX_W'(1);
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg - IDX_W'(1);
                end
            end
            // write an ascending run from idx up to position k-1
            cen_pkg::ST_FILL:
            begin
                mem_wr_en = 1'b1;
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = cen_pkg::ST_EMIT_RD;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    val_next = unit_inc;
                end
            end
            cen_pkg::ST_EMIT_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = cen_pkg::ST_EMIT_LD;
            end
            cen_pkg::ST_EMIT_LD:
            begin
                out_valid_next = 1'b1;
                out_value_next = mem_rd_data;
                out_last_next  = last_idx;
                out_exh_next   = 1'b0;
                // the first element at its bound marks the final combination
                out_final_next = (idx_reg == '0) ? unit_eq : out_final_reg;
                state_next     = cen_pkg::ST_EMIT_WAIT;
            end
            cen_pkg::ST_EMIT_WAIT:
            begin
                if (out_xact)
                begin
                    out_valid_next = 1'b0;
                    if (out_exh_reg || out_last_reg)
                    begin
                        state_next = cen_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next    = idx_reg + IDX_W'(1);
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = idx_reg + IDX_W'(1);
                        state_next  = cen_pkg::ST_EMIT_LD;
                    end
                end
            end
            default:
            begin
                state_next = cen_pkg::ST_IDLE;
            end
        endcase

        if (wr_en)
        begin
            started_next = 1'b0;
            done_next    = 1'b0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign element_value     = out_value_reg;
    assign last_element      = out_last_reg;
    assign final_combination = out_final_reg;
    assign exhausted         = out_exh_reg;

endmodule

`default_nettype wire

// ===== hdl/cen_checker.sv =====
`default_nettype none

module cen_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [cen_pkg::VALUE_W-1:0] element_value,
    input wire logic                        last_element,
    input wire logic                        final_combination,
    input wire logic                        exhausted
);

    // a pending result always blocks new requests
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && in_ready))
        else $error("request taken while a result is pending");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("still ready right after a request");

    a_exhausted_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exhausted |->
            (element_value == '0) && !last_element && !final_combination)
        else $error("exhausted result carries element data");

    a_element_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !exhausted |-> (element_value != '0))
        else $error("zero element in a combination");

    // closing transaction of a request frees the block at once
    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (last_element || exhausted) |=> in_ready)
        else $error("not ready after the last result");

endmodule

bind combination_enumerator cen_checker u_cen_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .element_value     (element_value),
    .last_element      (last_element),
    .final_combination (final_combination),
    .exhausted         (exhausted)
);

`default_nettype wire

// ===== tb/combination_enumerator_checker.sv =====
`default_nettype none

module combination_enumerator_checker #(
    parameter int MAX_CHOOSE   = 16,
    parameter int MAX_UNIVERSE = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [0:0]                  wr_index,
    input  wire logic [cen_pkg::VALUE_W-1:0] wr_data,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire logic                        restart,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic [cen_pkg::VALUE_W-1:0] element_value,
    input  wire logic                        last_element,
    input  wire logic                        final_combination,
    input  wire logic                        exhausted,
    output int                               pending_count,
    output int                               error_count
);

    typedef struct packed {
        logic [cen_pkg::VALUE_W-1:0] value;
        logic                        is_last;
        logic                        is_final;
        logic                        is_exhausted;
    } element_t;

    localparam element_t EXHAUSTED_ELEMENT = '{
        value: '0, is_last: 1'b0, is_final: 1'b0, is_exhausted: 1'b1
    };
    localparam int MAX_REPORTS = 10;

    element_t                    expected_elements[$];
    logic [cen_pkg::COUNT_W-1:0] choose_reg;
    logic [cen_pkg::VALUE_W-1:0] universe_reg;
    logic [cen_pkg::VALUE_W-1:0] combo[MAX_CHOOSE];
    bit                          started;
    bit                          done;

    initial
    begin
        pending_count = 0;
        error_count   = 0;
    end

    function automatic void load_first();
        for (int i = 0; i < MAX_CHOOSE; i++)
            combo[i] = cen_pkg::VALUE_W'(i + 1);
    endfunction

    function automatic void add_expected(input element_t e);
        expected_elements = {expected_elements, e};
    endfunction

    // moves combo to its lexicographic successor, 0 when none is left
    function automatic bit step_forward(int k, int m);
        for (int i = k; i > 0; i--)
        begin
            if (int'(combo[i-1]) < m - k + i)
            begin
                combo[i-1] = combo[i-1] + 1'b1;
                for (int j = i; j < k; j++)
                    combo[j] = combo[j-1] + 1'b1;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic predict_combination(input logic restart_req);
        int       k;
        int       m;
        bit       at_end;
        element_t e;
        k = int'(choose_reg);
        m = int'(universe_reg);
        if (k == 0 || k > m || k > MAX_CHOOSE || m > MAX_UNIVERSE)
            add_expected(EXHAUSTED_ELEMENT);
        else if (!restart_req && started && done)
            add_expected(EXHAUSTED_ELEMENT);
        else if (!restart_req && started && !step_forward(k, m))
        begin
            done = 1'b1;
            add_expected(EXHAUSTED_ELEMENT);
        end
        else
        begin
            if (restart_req || !started)
            begin
                load_first();
                started = 1'b1;
                done    = 1'b0;
            end
            at_end = 1'b1;
            for (int i = 0; i < k; i++)
                if (int'(combo[i]) != m - k + 1 + i)
                    at_end = 1'b0;
            for (int i = 0; i < k; i++)
            begin
                e.value        = combo[i];
                e.is_last      = (i == k - 1);
                e.is_final     = at_end;
                e.is_exhausted = 1'b0;
                add_expected(e);
            end
        end
    endtask

    task automatic log_mismatch(input string what, input element_t exp_e,
                                input element_t act_e);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display({"%0t: %s: expected value=%0d last=%0b final=%0b exh=%0b,",
                      " got value=%0d last=%0b final=%0b exh=%0b"},
                     $realtime, what, exp_e.value, exp_e.is_last, exp_e.is_final,
                     exp_e.is_exhausted, act_e.value, act_e.is_last, act_e.is_final,
                     act_e.is_exhausted);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        element_t act_e;
        element_t exp_e;
        if (!rst_n)
        begin
            choose_reg   = cen_pkg::COUNT_W'(1);
            universe_reg = cen_pkg::VALUE_W'(1);
            load_first();
            started = 1'b0;
            done    = 1'b0;
            expected_elements.delete();
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == cen_pkg::REG_CHOOSE_COUNT)
                    choose_reg = wr_data[cen_pkg::COUNT_W-1:0];
                else
                    universe_reg = wr_data;
                started = 1'b0;
                done    = 1'b0;
            end
            if (out_valid && out_ready)
            begin
                act_e = '{value: element_value, is_last: last_element,
                          is_final: final_combination, is_exhausted: exhausted};
                if (expected_elements.size() == 0)
                    log_mismatch("result transaction with nothing expected", '0, act_e);
                else
                begin
                    exp_e = expected_elements.pop_front();
                    if (act_e != exp_e)
                        log_mismatch("element mismatch", exp_e, act_e);
                end
            end
            if (in_valid && in_ready)
                predict_combination(restart);
        end
        pending_count = expected_elements.size();
    end

endmodule

`default_nettype wire

// ===== tb/combination_enumerator_tb.sv =====
`default_nettype none

module combination_enumerator_tb;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int PHASES          = 16;
    localparam int ITEMS_PER_PHASE = 16;
    localparam int SETTLE_CYCLES   = 80;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        wr_en = 1'b0;
    logic [0:0]                  wr_index = '0;
    logic [cen_pkg::VALUE_W-1:0] wr_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic                        restart = 1'b0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [cen_pkg::VALUE_W-1:0] element_value;
    logic                        last_element;
    logic                        final_combination;
    logic                        exhausted;
    int                          pending_count;
    int                          error_count;
    int                          cycle_count = 0;
    int                          send_idle_pct = 0;
    int                          recv_stall_pct = 0;

    int send_idle_by_mode[4]  = '{0, 79, 0, 17};
    int recv_stall_by_mode[4] = '{0, 0, 79, 17};

    combination_enumerator i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .wr_en             (wr_en),
        .wr_index          (wr_index),
        .wr_data           (wr_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .restart           (restart),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .element_value     (element_value),
        .last_element      (last_element),
        .final_combination (final_combination),
        .exhausted         (exhausted)
    );

    combination_enumerator_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .wr_en             (wr_en),
        .wr_index          (wr_index),
        .wr_data           (wr_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .restart           (restart),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .element_value     (element_value),
        .last_element      (last_element),
        .final_combination (final_combination),
        .exhausted         (exhausted),
        .pending_count     (pending_count),
        .error_count       (error_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("combination_enumerator_tb: done, errors");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // leaves valid high on return so back-to-back transactions need no gap
    task automatic send_request(input logic restart_req);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            restart  <= 1'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        restart  <= restart_req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cen_pkg::reg_index_t idx,
                             input logic [cen_pkg::VALUE_W-1:0] data);
        drain();
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic pick_config(output logic [cen_pkg::VALUE_W-1:0] kv,
                               output logic [cen_pkg::VALUE_W-1:0] mv,
                               output int restart_odds);
        int sel;
        sel = $urandom_range(99);
        restart_odds = 12;
        if (sel < 10)
        begin
            case ($urandom_range(2))
                0:
                begin
                    kv = $urandom_range(1) ? cen_pkg::VALUE_W'(0)
                                           : cen_pkg::VALUE_W'($urandom_range(17, 31));
                    mv = cen_pkg::VALUE_W'($urandom_range(1, 32));
                end
                1:
                begin
                    kv = cen_pkg::VALUE_W'($urandom_range(1, 16));
                    mv = cen_pkg::VALUE_W'($urandom_range(33, 63));
                end
                default:
                begin
                    mv = cen_pkg::VALUE_W'($urandom_range(1, 15));
                    kv = cen_pkg::VALUE_W'($urandom_range(int'(mv) + 1, 16));
                end
            endcase
        end
        else if (sel < 25)
        begin
            mv = cen_pkg::VALUE_W'($urandom_range(17, 32));
            kv = cen_pkg::VALUE_W'($urandom_range(1, 16));
            restart_odds = 10;
        end
        else
        begin
            mv = cen_pkg::VALUE_W'($urandom_range(1, 8));
            kv = cen_pkg::VALUE_W'($urandom_range(1, int'(mv)));
        end
        // upper data bit is dropped by the 5-bit count register
        kv[cen_pkg::VALUE_W-1] = 1'($urandom);
    endtask

    initial
    begin
        logic [cen_pkg::VALUE_W-1:0] kv;
        logic [cen_pkg::VALUE_W-1:0] mv;
        int                          restart_odds;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // reset configuration: first request without restart, then past the end
        repeat (3) send_request(1'b0);
        send_request(1'b1);

        write_reg(cen_pkg::REG_UNIVERSE_SIZE, 6'd4);
        write_reg(cen_pkg::REG_CHOOSE_COUNT, 6'b100011);
        repeat (5) send_request(1'b0);
        send_request(1'b1);
        drain();
        send_request(1'b0);

        write_reg(cen_pkg::REG_UNIVERSE_SIZE, 6'd32);
        write_reg(cen_pkg::REG_CHOOSE_COUNT, 6'd16);
        send_request(1'b1);
        repeat (2) send_request(1'b0);

        // k equals m: only one combination
        write_reg(cen_pkg::REG_UNIVERSE_SIZE, 6'd16);
        repeat (2) send_request(1'b0);

        // invalid settings
        write_reg(cen_pkg::REG_CHOOSE_COUNT, 6'b100000);
        send_request(1'b1);
        write_reg(cen_pkg::REG_CHOOSE_COUNT, 6'd5);
        write_reg(cen_pkg::REG_UNIVERSE_SIZE, 6'd3);
        send_request(1'b0);
        write_reg(cen_pkg::REG_UNIVERSE_SIZE, 6'd63);
        write_reg(cen_pkg::REG_CHOOSE_COUNT, 6'd2);
        send_request(1'b1);
        write_reg(cen_pkg::REG_UNIVERSE_SIZE, 6'd32);
        write_reg(cen_pkg::REG_CHOOSE_COUNT, 6'd17);
        send_request(1'b0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            pick_config(kv, mv, restart_odds);
            if ($urandom_range(1))
            begin
                write_reg(cen_pkg::REG_CHOOSE_COUNT, kv);
                write_reg(cen_pkg::REG_UNIVERSE_SIZE, mv);
            end
            else
            begin
                write_reg(cen_pkg::REG_UNIVERSE_SIZE, mv);
                write_reg(cen_pkg::REG_CHOOSE_COUNT, kv);
            end
            send_idle_pct  = send_idle_by_mode[ph % 4];
            recv_stall_pct = recv_stall_by_mode[ph % 4];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(19) == 0)
                    drain();
                send_request($urandom_range(restart_odds - 1) == 0);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("combination_enumerator_tb: done, clean");
        else
            $display("combination_enumerator_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/cen_pkg.sv
hdl/cen_store.sv
hdl/cen_unit.sv
hdl/combination_enumerator.sv
hdl/cen_checker.sv
tb/combination_enumerator_checker.sv
tb/combination_enumerator_tb.sv
